>>> sv/rrmt_pkg.sv
// Shared types and constants for the register rename map table.
package rrmt_pkg;

  // Item field widths, fixed by the interface.
  localparam int CMD_W  = 2;
  localparam int ARCH_W = 5;
  localparam int PHYS_W = 7;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_WAKEUP = 2'd3;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_in;  // capture the accepted item
    logic exec;     // apply the item to the table and load the result register
  } rrmt_ctrl_t;

endpackage

>>> sv/rrmt_ctrl.sv
// Control state machine for the register rename map table.
module rrmt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output rrmt_pkg::rrmt_ctrl_t ctrl
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic out_free;

  // result register free, or being drained this cycle
  assign out_free = !out_valid || !out_stall;

  assign in_stall     = (state == ST_EXEC);
  assign ctrl.load_in = (state == ST_IDLE) && in_valid;
  assign ctrl.exec    = (state == ST_EXEC) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (ctrl.exec) begin
      out_valid_next = 1'b1;
    end else begin
      out_valid_next = out_valid && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> sv/rrmt_datapath.sv
// Map table storage, wakeup compare lanes and result register.
module rrmt_datapath #(
  parameter int NUM_ARCH_REGS = 32,
  parameter int NUM_PHYS_REGS = 128,
  parameter int ARCH_IDX_W    = 5,
  parameter int ENTRY_W       = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rrmt_pkg::rrmt_ctrl_t          ctrl,
  input  logic [rrmt_pkg::CMD_W-1:0]    command,
  input  logic [rrmt_pkg::ARCH_W-1:0]   arch_reg,
  input  logic [rrmt_pkg::PHYS_W-1:0]   phys_reg,
  input  logic                          phys_ready,
  output logic [rrmt_pkg::PHYS_W-1:0]   mapped_phys,
  output logic                          mapped_ready
);

  localparam int ARCH_EXT_W = ARCH_IDX_W + rrmt_pkg::ARCH_W;

  // captured item
  logic [rrmt_pkg::CMD_W-1:0]  cmd_q;
  logic [rrmt_pkg::ARCH_W-1:0] arch_q;
  logic [rrmt_pkg::PHYS_W-1:0] phys_q;
  logic                        rdy_q;

  logic [ENTRY_W-1:0] entry_phys      [NUM_ARCH_REGS];
  logic               entry_ready     [NUM_ARCH_REGS];
  logic [ENTRY_W-1:0] entry_phys_next [NUM_ARCH_REGS];
  logic               entry_ready_next[NUM_ARCH_REGS];

  logic                  arch_ok;
  logic                  phys_ok;
  logic [ARCH_EXT_W-1:0] arch_ext;
  logic [ARCH_IDX_W-1:0] idx;
  logic                  do_set;
  logic                  do_clear;
  logic                  do_wake;

  assign arch_ok  = (32'(arch_q) < NUM_ARCH_REGS);
  assign phys_ok  = (32'(phys_q) < NUM_PHYS_REGS);
  assign arch_ext = ARCH_EXT_W'(arch_q);
  assign idx      = arch_ext[ARCH_IDX_W-1:0];

  always_comb begin
    do_set   = 1'b0;
    do_clear = 1'b0;
    do_wake  = 1'b0;
    unique case (cmd_q)
      rrmt_pkg::CMD_LOOKUP: ;
      rrmt_pkg::CMD_SET:    do_set   = arch_ok && phys_ok;
      rrmt_pkg::CMD_CLEAR:  do_clear = arch_ok;
      rrmt_pkg::CMD_WAKEUP: do_wake  = phys_ok;
      default: ;
    endcase
  end

  // one update lane per entry; wakeup compares every entry at once
  always_comb begin
    for (int i = 0; i < NUM_ARCH_REGS; i++) begin
      entry_phys_next[i]  = entry_phys[i];
      entry_ready_next[i] = entry_ready[i];
      if (do_wake && !entry_ready[i] && (entry_phys[i] == ENTRY_W'(phys_q))) begin
        entry_ready_next[i] = 1'b1;
      end
      if (idx == ARCH_IDX_W'(i)) begin
        if (do_set) begin
          entry_phys_next[i]  = ENTRY_W'(phys_q);
          entry_ready_next[i] = rdy_q;
        end else if (do_clear) begin
          entry_ready_next[i] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      cmd_q  <= command;
      arch_q <= arch_reg;
      phys_q <= phys_reg;
      rdy_q  <= phys_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ARCH_REGS; i++) begin
        entry_phys[i]  <= ENTRY_W'(i);
        entry_ready[i] <= 1'b1;
      end
    end else if (ctrl.exec) begin
      for (int i = 0; i < NUM_ARCH_REGS; i++) begin
        entry_phys[i]  <= entry_phys_next[i];
        entry_ready[i] <= entry_ready_next[i];
      end
    end
  end

  // result register: addressed entry after the update, zero when out of range
  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      if (arch_ok) begin
        mapped_phys  <= entry_phys_next[idx][rrmt_pkg::PHYS_W-1:0];
        mapped_ready <= entry_ready_next[idx];
      end else begin
        mapped_phys  <= '0;
        mapped_ready <= 1'b0;
      end
    end
  end

endmodule

>>> sv/register_rename_map_table_unit.sv
// Register rename map table: top level with controller and datapath.
// An accepted item is captured, then applied and its result registered once the
//   result register is free. Items go one at a time through the capture/execute
//   loop; the next item is taken while a finished result still waits on out_stall.
// Reset (rst, synchronous): entry i maps to physical register i and is ready,
//   controller idle, no result pending.
module register_rename_map_table_unit #(
  parameter int NUM_ARCH_REGS = 32,
  parameter int NUM_PHYS_REGS = 128
) (
  input  logic                        clk,
  input  logic                        rst,
  // item input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rrmt_pkg::CMD_W-1:0]  command,
  input  logic [rrmt_pkg::ARCH_W-1:0] arch_reg,
  input  logic [rrmt_pkg::PHYS_W-1:0] phys_reg,
  input  logic                        phys_ready,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rrmt_pkg::PHYS_W-1:0] mapped_phys,
  output logic                        mapped_ready
);

  // Index width for the table; NUM_ARCH_REGS >= 2 so at least one bit.
  localparam int ARCH_IDX_W = $clog2(NUM_ARCH_REGS);
  // Stored physical number must also hold the reset value i of the highest entry.
  localparam int ENTRY_W = (ARCH_IDX_W > rrmt_pkg::PHYS_W) ? ARCH_IDX_W
                                                           : rrmt_pkg::PHYS_W;

  rrmt_pkg::rrmt_ctrl_t ctrl;

  // Controller: idle/execute loop, owns both handshakes.
  rrmt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl)
  );

  // Datapath: item capture, table with per-entry wakeup compare, result register.
  rrmt_datapath #(
    .NUM_ARCH_REGS (NUM_ARCH_REGS),
    .NUM_PHYS_REGS (NUM_PHYS_REGS),
    .ARCH_IDX_W    (ARCH_IDX_W),
    .ENTRY_W       (ENTRY_W)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .command      (command),
    .arch_reg     (arch_reg),
    .phys_reg     (phys_reg),
    .phys_ready   (phys_ready),
    .mapped_phys  (mapped_phys),
    .mapped_ready (mapped_ready)
  );

  // An accepted item holds the block busy for the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted but block not busy next cycle");

  // Capture and execute never happen in the same cycle.
  assert property (@(posedge clk) disable iff (rst)
    !(ctrl.load_in && ctrl.exec))
    else $error("capture and execute overlap");

  // Executing an item always presents a result next cycle.
  assert property (@(posedge clk) disable iff (rst)
    ctrl.exec |=> out_valid)
    else $error("executed item produced no result");

  // A result appears only after an item sat in the execute state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a preceding execute cycle");

endmodule

>>> bench/tb_register_rename_map_table_unit.sv
// Self-checking testbench for the register rename map table unit.
`timescale 1ns / 100ps

module tb_register_rename_map_table_unit;

  localparam int NUM_ARCH   = 32;
  localparam int NUM_PHYS   = 128;
  localparam int PHASE_OPS  = 420;   // random items per throttling phase
  localparam int STALL_LIMIT = 4000; // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES = 10;  // settle time after the last result

  // One rename/wakeup command as it travels on the input channel.
  typedef struct {
    logic [rrmt_pkg::CMD_W-1:0]  cmd;
    logic [rrmt_pkg::ARCH_W-1:0] arch;
    logic [rrmt_pkg::PHYS_W-1:0] phys;
    logic                        rdy;
  } rename_op_t;

  // One table entry as reported on the result channel.
  typedef struct {
    logic [rrmt_pkg::PHYS_W-1:0] phys;
    logic                        rdy;
  } map_entry_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #4 clk = ~clk;

  // DUT ports; every input starts at a known value
  logic                        in_valid     = 1'b0;
  logic                        in_stall;
  logic [rrmt_pkg::CMD_W-1:0]  command      = rrmt_pkg::CMD_LOOKUP;
  logic [rrmt_pkg::ARCH_W-1:0] arch_reg     = '0;
  logic [rrmt_pkg::PHYS_W-1:0] phys_reg     = '0;
  logic                        phys_ready   = 1'b0;
  logic                        out_valid;
  logic                        out_stall    = 1'b0;
  logic [rrmt_pkg::PHYS_W-1:0] mapped_phys;
  logic                        mapped_ready;

  register_rename_map_table_unit #(
    .NUM_ARCH_REGS(NUM_ARCH),
    .NUM_PHYS_REGS(NUM_PHYS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .arch_reg     (arch_reg),
    .phys_reg     (phys_reg),
    .phys_ready   (phys_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mapped_phys  (mapped_phys),
    .mapped_ready (mapped_ready)
  );

  // Shadow copy of the alias table, updated in acceptance order.
  logic [rrmt_pkg::PHYS_W-1:0] shadow_phys  [NUM_ARCH];
  logic                        shadow_ready [NUM_ARCH];

  rename_op_t pending_ops [$];   // items waiting to be driven
  map_entry_t expected_entries [$];  // entries the DUT still owes us
  rename_op_t cur_op;            // item currently on the input port

  // Throttling knobs, percent of cycles; changed by the stimulus process per phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned err_count = 0;
  int unsigned ops_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned idle_cycles = 0;
  int unsigned cmd_count [4] = '{0, 0, 0, 0};
  int unsigned wakes_fired = 0;  // wakeups that flipped at least one entry
  bit          drv_hold;
  logic [rrmt_pkg::PHYS_W-1:0] tag_base;   // small tag pool so wakeups actually hit

  // Apply one command to the shadow table and return the addressed entry after update.
  function automatic map_entry_t rename_table_step(rename_op_t op);
    map_entry_t res;
    bit         woke;
    woke = 1'b0;
    if (op.cmd == rrmt_pkg::CMD_WAKEUP) begin
      // Tag broadcast: every not-ready entry holding this tag becomes ready.
      if (op.phys < NUM_PHYS) begin
        for (int i = 0; i < NUM_ARCH; i++) begin
          if (shadow_phys[i] == op.phys && !shadow_ready[i]) begin
            shadow_ready[i] = 1'b1;
            woke = 1'b1;
          end
        end
      end
      if (woke) wakes_fired++;
    end else if (op.arch < NUM_ARCH) begin
      if (op.cmd == rrmt_pkg::CMD_SET && op.phys < NUM_PHYS) begin
        shadow_phys[op.arch]  = op.phys;
        shadow_ready[op.arch] = op.rdy;
      end else if (op.cmd == rrmt_pkg::CMD_CLEAR) begin
        shadow_ready[op.arch] = 1'b0;
      end
    end
    if (op.arch < NUM_ARCH) begin
      res.phys = shadow_phys[op.arch];
      res.rdy  = shadow_ready[op.arch];
    end else begin
      res.phys = '0;
      res.rdy  = 1'b0;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] MISMATCH on result %0d: %s got %0d, expected %0d",
             $time, results_checked, what, got, want);
    err_count++;
  endtask

  task automatic queue_op(input logic [rrmt_pkg::CMD_W-1:0] c, input int a, input int p,
                          input bit r);
    rename_op_t op;
    op.cmd  = c;
    op.arch = a[rrmt_pkg::ARCH_W-1:0];
    op.phys = p[rrmt_pkg::PHYS_W-1:0];
    op.rdy  = r;
    pending_ops.push_back(op);
  endtask

  // Random item shaped like real rename traffic: allocate a tag not-ready,
  // read sources, broadcast the tag later. A slice is plain noise.
  task automatic queue_random_op();
    int unsigned pick;
    int          tag;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 75)
      tag = (tag_base + $urandom_range(15)) % NUM_PHYS;
    else
      tag = $urandom_range(NUM_PHYS - 1);
    if (pick < 30)
      queue_op(rrmt_pkg::CMD_SET, $urandom_range(NUM_ARCH - 1), tag,
               $urandom_range(99) < 20);
    else if (pick < 55)
      queue_op(rrmt_pkg::CMD_LOOKUP, $urandom_range(NUM_ARCH - 1),
               $urandom_range(NUM_PHYS - 1), 1'($urandom_range(1)));
    else if (pick < 80)
      queue_op(rrmt_pkg::CMD_WAKEUP, $urandom_range(NUM_ARCH - 1), tag,
               1'($urandom_range(1)));
    else if (pick < 90)
      queue_op(rrmt_pkg::CMD_CLEAR, $urandom_range(NUM_ARCH - 1),
               $urandom_range(NUM_PHYS - 1), 1'($urandom_range(1)));
    else begin
      case ($urandom_range(3))
        0: queue_op(rrmt_pkg::CMD_LOOKUP, $urandom_range(31), $urandom_range(127),
                    1'($urandom_range(1)));
        1: queue_op(rrmt_pkg::CMD_SET,    $urandom_range(31), $urandom_range(127),
                    1'($urandom_range(1)));
        2: queue_op(rrmt_pkg::CMD_CLEAR,  $urandom_range(31), $urandom_range(127),
                    1'($urandom_range(1)));
        default:
           queue_op(rrmt_pkg::CMD_WAKEUP, $urandom_range(31), $urandom_range(127),
                    1'($urandom_range(1)));
      endcase
    end
  endtask

  // Driver: presents items from pending_ops, holds them steady under in_stall,
  // and predicts the result at the edge where the item is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_entries.push_back(rename_table_step(cur_op));
        cmd_count[cur_op.cmd]++;
        ops_accepted++;
        drv_hold = 1'b0;
      end else begin
        drv_hold = in_valid;  // stalled item stays on the bus untouched
      end
      if (!drv_hold) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_op = pending_ops.pop_front();
          command    <= cur_op.cmd;
          arch_reg   <= cur_op.arch;
          phys_reg   <= cur_op.phys;
          phys_ready <= cur_op.rdy;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each taken result against the oldest prediction and
  // throttles the result channel.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_entries.size() == 0) begin
          report_mismatch("unexpected result, mapped_phys", int'(mapped_phys), -1);
        end else begin
          map_entry_t want;
          want = expected_entries.pop_front();
          if (mapped_phys !== want.phys)
            report_mismatch("mapped_phys", int'(mapped_phys), int'(want.phys));
          if (mapped_ready !== want.rdy)
            report_mismatch("mapped_ready", int'(mapped_ready), int'(want.rdy));
        end
        results_checked++;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: counts cycles with no handshake on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("Timeout: no handshake for %0d cycles, %0d results still owed",
             STALL_LIMIT, expected_entries.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Block until every queued item is taken and every predicted result is back.
  task automatic drain_all();
    while (pending_ops.size() != 0 || in_valid) @(posedge clk);
    while (expected_entries.size() != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    for (int i = 0; i < NUM_ARCH; i++) begin
      shadow_phys[i]  = i[rrmt_pkg::PHYS_W-1:0];
      shadow_ready[i] = 1'b1;
    end
    tag_base = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset contents at both ends of the table
    queue_op(rrmt_pkg::CMD_LOOKUP, 0, 127, 1'b1);
    queue_op(rrmt_pkg::CMD_LOOKUP, 31, 0, 1'b0);
    // Set with field extremes, both ready values
    queue_op(rrmt_pkg::CMD_SET, 0, 127, 1'b0);
    queue_op(rrmt_pkg::CMD_SET, 31, 0, 1'b1);
    queue_op(rrmt_pkg::CMD_LOOKUP, 0, 0, 1'b0);
    // Clear ready, then clear again on an entry already not ready
    queue_op(rrmt_pkg::CMD_CLEAR, 31, 127, 1'b1);
    queue_op(rrmt_pkg::CMD_CLEAR, 31, 0, 1'b0);
    // Wakeup reported through a different entry than the one it wakes
    queue_op(rrmt_pkg::CMD_WAKEUP, 0, 0, 1'b1);
    queue_op(rrmt_pkg::CMD_LOOKUP, 31, 55, 1'b0);
    // One tag shared by two not-ready entries: a single broadcast wakes both
    queue_op(rrmt_pkg::CMD_SET, 5, 77, 1'b0);
    queue_op(rrmt_pkg::CMD_SET, 6, 77, 1'b0);
    queue_op(rrmt_pkg::CMD_WAKEUP, 5, 77, 1'b0);
    queue_op(rrmt_pkg::CMD_LOOKUP, 6, 1, 1'b1);
    // Tag that matches only ready entries changes nothing
    queue_op(rrmt_pkg::CMD_WAKEUP, 6, 77, 1'b1);
    // Tag with no match while the reported entry stays not ready
    queue_op(rrmt_pkg::CMD_WAKEUP, 0, 100, 1'b0);
    // The current mapping of entry 0 (tag 127) wakes it
    queue_op(rrmt_pkg::CMD_WAKEUP, 0, 127, 1'b0);
    // Entry 10 aliases the reset mapping of entry 20; one broadcast wakes both
    queue_op(rrmt_pkg::CMD_SET, 10, 20, 1'b0);
    queue_op(rrmt_pkg::CMD_CLEAR, 20, 0, 1'b0);
    queue_op(rrmt_pkg::CMD_WAKEUP, 15, 20, 1'b1);
    queue_op(rrmt_pkg::CMD_LOOKUP, 10, 127, 1'b1);
    queue_op(rrmt_pkg::CMD_LOOKUP, 20, 127, 1'b1);
    queue_op(rrmt_pkg::CMD_SET, 17, 85, 1'b1);
    queue_op(rrmt_pkg::CMD_LOOKUP, 17, 42, 1'b0);
    drain_all();

    // Random traffic in four throttling phases; each phase boundary lets the
    // unit go completely idle before the next burst starts.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      tag_base = rrmt_pkg::PHYS_W'($urandom_range(NUM_PHYS - 1));
      for (int n = 0; n < PHASE_OPS; n++) begin
        // move the tag pool now and then so fresh tags show up
        if (n % 100 == 99) tag_base = rrmt_pkg::PHYS_W'($urandom_range(NUM_PHYS - 1));
        queue_random_op();
      end
      drain_all();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_entries.size() != 0)
      report_mismatch("results never delivered", 0, expected_entries.size());

    $display("Covered %0d items (lookup %0d, set %0d, clear %0d, wakeup %0d), %0d results",
             ops_accepted, cmd_count[rrmt_pkg::CMD_LOOKUP], cmd_count[rrmt_pkg::CMD_SET],
             cmd_count[rrmt_pkg::CMD_CLEAR], cmd_count[rrmt_pkg::CMD_WAKEUP],
             results_checked);
    $display("%0d wakeups hit waiting entries; %0d mismatches across four throttle phases",
             wakes_fired, err_count);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
